// File: sv/rqbs_pkg.sv
// ----------------------------------------------------------------------------
// rqbs_pkg
// Shared constants, codes and types of the retry queue backoff scheduler.
// ----------------------------------------------------------------------------
package rqbs_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int CAT_COUNT  = 5;
    localparam int CAT_W      = 3;
    localparam int TIME_W     = 32;
    localparam int ATT_W      = 4;

    // Field widths of the item and result ports.
    localparam int MODE_W    = 3;
    localparam int RC_W      = 3;
    localparam int ENG_W     = 2;
    localparam int PEND_W    = 5;
    localparam int CNT_W     = 32;

    // Configuration register widths and reset values.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int BASE_W     = 16;
    localparam int CAP_W      = 20;
    localparam int DELAY_W    = CAP_W + 1;

    localparam logic              RST_ENABLED  = 1'b1;
    localparam logic [ATT_W-1:0]  RST_MAX_ATT  = 4'd5;
    localparam logic [BASE_W-1:0] RST_BASE     = 16'd2000;
    localparam logic [CAP_W-1:0]  RST_CAP      = 20'd60000;
    localparam logic [CAT_COUNT-1:0] RST_HP_MASK = 5'd3;

    // Item modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_OUTCOME   = 3'd1,
        MODE_CANCEL    = 3'd2,
        MODE_RETRY_NOW = 3'd3,
        MODE_FORCE     = 3'd4
    } t_mode;

    // Result codes.
    typedef enum logic [RC_W-1:0] {
        RC_OK      = 3'd0,
        RC_NOCHG   = 3'd1,
        RC_FULL    = 3'd2,
        RC_NOCLOUD = 3'd3,
        RC_FAIL    = 3'd4,
        RC_CANCEL  = 3'd5,
        RC_DIS     = 3'd6
    } t_result;

    // Engine state codes.
    typedef enum logic [ENG_W-1:0] {
        ENG_IDLE  = 2'd0,
        ENG_PROC  = 2'd1,
        ENG_RETRY = 2'd2,
        ENG_DIS   = 2'd3
    } t_eng;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED  = 3'd0,
        CFG_MAX_ATT  = 3'd1,
        CFG_BASE     = 3'd2,
        CFG_CAP      = 3'd3,
        CFG_HP_MASK  = 3'd4
    } t_cfg_idx;

    // One slot record in the information memory.
    typedef struct packed {
        logic [CAT_W-1:0] cat;
        logic             hi;
        logic [ATT_W-1:0] att;
    } t_slot_info;

    localparam int INFO_W = $bits(t_slot_info);

endpackage

// File: sv/rqbs_ram.sv
// ----------------------------------------------------------------------------
// rqbs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rqbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/retry_queue_backoff_scheduler.sv
// ----------------------------------------------------------------------------
// retry_queue_backoff_scheduler
// Each accepted item gives exactly one result item. A tick inserts the new
// categories (at most five) and may then walk the slot table through the
// single read port of the slot memories, one slot per cycle. An outcome
// report reads the slot and updates it; when the slot is rescheduled, the
// backoff delay is doubled step by step and the new ready time is written.
// Retry-now sweeps the time memory (one slot a cycle) before inserting;
// cancel, unknown modes and items seen while the engine is disabled go
// straight to the result. A finished result waits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
module retry_queue_backoff_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [rqbs_pkg::MODE_W-1:0]       i_mode,
    input  logic [rqbs_pkg::CAT_COUNT-1:0]    i_dirty_flags,
    input  logic [rqbs_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                              i_cloud_ready,
    input  logic                              i_attempt_ok,
    // Result item channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_grant_valid,
    output logic [rqbs_pkg::CAT_W-1:0]        o_grant_category,
    output logic [rqbs_pkg::CAT_COUNT-1:0]    o_clear_dirty_mask,
    output logic [rqbs_pkg::RC_W-1:0]         o_result_code,
    output logic [rqbs_pkg::ENG_W-1:0]        o_engine_state,
    output logic [rqbs_pkg::PEND_W-1:0]       o_pending_count,
    output logic                              o_item_dropped,
    output logic [rqbs_pkg::CNT_W-1:0]        o_success_count,
    output logic [rqbs_pkg::CNT_W-1:0]        o_drop_count,
    output logic [rqbs_pkg::CNT_W-1:0]        o_retry_count_total,
    output logic [rqbs_pkg::TIME_W-1:0]       o_last_success_ms,
    // Configuration write port.
    input  logic                              i_cfg_wr_en,
    input  logic [rqbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rqbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import rqbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_DECIDE,
        S_OUT_READ,
        S_OUT_UPD,
        S_BACKOFF,
        S_ZERO,
        S_RESULT
    } t_fsm;

    // Control and configuration state.
    t_fsm                   r_fsm;
    logic                   r_enabled;
    logic [ATT_W-1:0]       r_max_att;
    logic [BASE_W-1:0]      r_base;
    logic [CAP_W-1:0]       r_cap;
    logic [CAT_COUNT-1:0]   r_hp_mask;
    logic [SLOT_COUNT-1:0]  r_slot_valid;
    logic [CAT_COUNT-1:0]   r_cat_present;
    logic [COUNT_W-1:0]     r_used;
    logic                   r_pending;
    logic [SLOT_W-1:0]      r_attempt_slot;
    t_eng                   r_eng;
    t_result                r_last;
    logic [CNT_W-1:0]       r_success_total;
    logic [CNT_W-1:0]       r_drop_total;
    logic [CNT_W-1:0]       r_retry_total;
    logic [TIME_W-1:0]      r_last_success;
    logic                   r_out_valid;

    // Per-item working registers.
    t_mode                  r_mode;
    logic [TIME_W-1:0]      r_now;
    logic                   r_cloud;
    logic                   r_ok;
    logic [CAT_COUNT-1:0]   r_ins_mask;
    logic                   r_full;
    logic [COUNT_W-1:0]     r_idx;
    logic                   r_best_found;
    logic                   r_best_hi;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [CAT_W-1:0]       r_best_cat;
    logic                   r_gv;
    logic [CAT_W-1:0]       r_gcat;
    logic [CAT_COUNT-1:0]   r_clr;
    logic                   r_drop;
    logic [DELAY_W-1:0]     r_delay;
    logic [ATT_W-1:0]       r_bo_cnt;

    // Result registers.
    logic                   r_o_gv;
    logic [CAT_W-1:0]       r_o_gcat;
    logic [CAT_COUNT-1:0]   r_o_clr;
    logic [RC_W-1:0]        r_o_rc;
    logic [ENG_W-1:0]       r_o_eng;
    logic [PEND_W-1:0]      r_o_pend;
    logic                   r_o_drop;
    logic [CNT_W-1:0]       r_o_succ;
    logic [CNT_W-1:0]       r_o_dropc;
    logic [CNT_W-1:0]       r_o_retry;
    logic [TIME_W-1:0]      r_o_last;

    // Memory ports.
    logic                   info_we;
    logic [SLOT_W-1:0]      info_waddr;
    t_slot_info             info_wdata;
    logic [INFO_W-1:0]      info_rraw;
    t_slot_info             info_rdata;
    logic                   time_we;
    logic [SLOT_W-1:0]      time_waddr;
    logic [TIME_W-1:0]      time_wdata;
    logic [TIME_W-1:0]      time_rdata;
    logic [SLOT_W-1:0]      rd_addr;

    // Helper signals.
    logic                   in_acc;
    logic [SLOT_W-1:0]      free_idx;
    logic [CAT_W-1:0]       ins_cat;
    logic [CAT_COUNT-1:0]   ins_bit;
    logic                   table_full;
    logic                   ins_go;
    logic [SLOT_W-1:0]      scan_slot;
    logic                   scan_ready;
    logic                   slot_hit;
    logic [ATT_W-1:0]       att_next;
    logic [CAT_COUNT-1:0]   out_cat_bit;
    logic [DELAY_W-1:0]     delay_dbl;
    logic [DELAY_W-1:0]     cap_ext;
    t_result                rc_now;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_fsm != S_IDLE);

    // Lowest free slot and lowest category still to insert.
    always_comb begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        ins_cat = '0;
        for (int c = CAT_COUNT - 1; c >= 0; c--) begin
            if (r_ins_mask[c]) begin
                ins_cat = CAT_W'(c);
            end
        end
    end

    assign ins_bit    = CAT_COUNT'(1) << ins_cat;
    assign table_full = (r_used >= COUNT_W'(SLOT_COUNT));
    assign ins_go     = (r_fsm == S_INSERT) && (r_ins_mask != '0) && !table_full;

    // Scan data belongs to the slot addressed in the previous cycle.
    assign scan_slot  = SLOT_W'(r_idx - 1'b1);
    assign scan_ready = r_slot_valid[scan_slot] && (time_rdata <= r_now);

    // Outcome report helpers.
    assign info_rdata  = t_slot_info'(info_rraw);
    assign slot_hit    = r_pending && r_slot_valid[r_attempt_slot];
    assign att_next    = info_rdata.att + 1'b1;
    assign out_cat_bit = CAT_COUNT'(1) << info_rdata.cat;
    assign delay_dbl   = r_delay << 1;
    assign cap_ext     = DELAY_W'(r_cap);

    // Memory address and write selection. Accesses are sequenced so that no
    // read of an entry overlaps a pending write to it.
    always_comb begin
        rd_addr    = (r_fsm == S_SCAN) ? r_idx[SLOT_W-1:0] : r_attempt_slot;
        info_we    = 1'b0;
        info_waddr = free_idx;
        info_wdata = '{cat: ins_cat, hi: r_hp_mask[ins_cat], att: '0};
        time_we    = 1'b0;
        time_waddr = free_idx;
        time_wdata = '0;
        case (r_fsm)
            S_INSERT: begin
                info_we = ins_go;
                time_we = ins_go;
            end
            S_OUT_UPD: begin
                info_we    = slot_hit && !r_ok;
                info_waddr = r_attempt_slot;
                info_wdata = '{cat: info_rdata.cat, hi: info_rdata.hi, att: att_next};
            end
            S_ZERO: begin
                time_we    = 1'b1;
                time_waddr = r_idx[SLOT_W-1:0];
            end
            S_BACKOFF: begin
                time_we    = (r_bo_cnt == '0);
                time_waddr = r_attempt_slot;
                time_wdata = r_now + TIME_W'(r_delay);
            end
            default: begin
            end
        endcase
    end

    // Result code of the finishing item.
    always_comb begin
        if (!r_enabled) begin
            rc_now = RC_DIS;
        end else begin
            case (r_mode)
                MODE_CANCEL:    rc_now = RC_CANCEL;
                MODE_RETRY_NOW: rc_now = RC_OK;
                MODE_FORCE:     rc_now = r_full ? RC_FULL : RC_OK;
                default:        rc_now = r_last;
            endcase
        end
    end

    rqbs_ram #(
        .WIDTH (INFO_W),
        .DEPTH (SLOT_COUNT)
    ) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (info_waddr),
        .i_wdata (info_wdata),
        .i_raddr (rd_addr),
        .o_rdata (info_rraw)
    );

    rqbs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_COUNT)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (time_wdata),
        .i_raddr (rd_addr),
        .o_rdata (time_rdata)
    );

    // Sequencer, table bookkeeping, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm           <= S_IDLE;
            r_enabled       <= RST_ENABLED;
            r_max_att       <= RST_MAX_ATT;
            r_base          <= RST_BASE;
            r_cap           <= RST_CAP;
            r_hp_mask       <= RST_HP_MASK;
            r_slot_valid    <= '0;
            r_cat_present   <= '0;
            r_used          <= '0;
            r_pending       <= 1'b0;
            r_attempt_slot  <= '0;
            r_eng           <= ENG_IDLE;
            r_last          <= RC_NOCHG;
            r_success_total <= '0;
            r_drop_total    <= '0;
            r_retry_total   <= '0;
            r_last_success  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // The user must issue configuration writes only while the engine is idle; the block does not enforce it.
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLED: begin
                        r_enabled <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_eng <= ENG_DIS;
                        end else begin
                            r_eng <= (r_used != '0) ? ENG_RETRY : ENG_IDLE;
                        end
                    end
                    CFG_MAX_ATT: r_max_att <= i_cfg_data[ATT_W-1:0];
                    CFG_BASE:    r_base    <= i_cfg_data[BASE_W-1:0];
                    CFG_CAP:     r_cap     <= i_cfg_data[CAP_W-1:0];
                    CFG_HP_MASK: r_hp_mask <= i_cfg_data[CAT_COUNT-1:0];
                    default: begin
                    end
                endcase
            end

            // The result register empties when its item is taken.
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_fsm)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode <= t_mode'(i_mode);
                        r_now  <= i_now_ms;
                        r_cloud <= i_cloud_ready;
                        r_ok   <= i_attempt_ok;
                        r_full <= 1'b0;
                        r_gv   <= 1'b0;
                        r_gcat <= '0;
                        r_clr  <= '0;
                        r_drop <= 1'b0;
                        r_idx  <= '0;
                        if (!r_enabled) begin
                            r_fsm <= S_RESULT;
                        end else begin
                            case (t_mode'(i_mode))
                                MODE_TICK: begin
                                    r_ins_mask <= i_dirty_flags & ~r_cat_present;
                                    r_fsm      <= S_INSERT;
                                end
                                MODE_OUTCOME: begin
                                    r_fsm <= S_OUT_READ;
                                end
                                MODE_CANCEL: begin
                                    r_slot_valid  <= '0;
                                    r_cat_present <= '0;
                                    r_used        <= '0;
                                    r_pending     <= 1'b0;
                                    r_eng         <= ENG_IDLE;
                                    r_last        <= RC_CANCEL;
                                    r_fsm         <= S_RESULT;
                                end
                                MODE_RETRY_NOW: begin
                                    r_ins_mask <= i_dirty_flags & ~r_cat_present;
                                    r_fsm      <= S_ZERO;
                                end
                                MODE_FORCE: begin
                                    r_ins_mask <= ~r_cat_present;
                                    r_fsm      <= S_INSERT;
                                end
                                default: begin
                                    r_fsm <= S_RESULT;
                                end
                            endcase
                        end
                    end
                end

                // Clear every ready time, one slot a cycle.
                S_ZERO: begin
                    if (r_idx == COUNT_W'(SLOT_COUNT - 1)) begin
                        r_fsm <= S_INSERT;
                    end
                    r_idx <= r_idx + 1'b1;
                end

                // Insert one category a cycle, then settle the engine state.
                S_INSERT: begin
                    if (r_ins_mask != '0) begin
                        r_ins_mask <= r_ins_mask & ~ins_bit;
                        if (table_full) begin
                            r_full <= 1'b1;
                        end else begin
                            r_slot_valid[free_idx] <= 1'b1;
                            r_cat_present          <= r_cat_present | ins_bit;
                            r_used                 <= r_used + 1'b1;
                        end
                    end else begin
                        case (r_mode)
                            MODE_TICK: begin
                                if (r_eng == ENG_IDLE && r_used != '0) begin
                                    r_eng <= ENG_RETRY;
                                end
                                if (r_pending) begin
                                    r_fsm <= S_RESULT;
                                end else if (r_used == '0) begin
                                    r_eng <= ENG_IDLE;
                                    r_fsm <= S_RESULT;
                                end else begin
                                    r_idx        <= '0;
                                    r_best_found <= 1'b0;
                                    r_best_hi    <= 1'b0;
                                    r_fsm        <= S_SCAN;
                                end
                            end
                            MODE_RETRY_NOW: begin
                                if (r_used != '0) begin
                                    r_eng <= ENG_RETRY;
                                end
                                r_fsm <= S_RESULT;
                            end
                            default: begin
                                r_fsm <= S_RESULT;
                            end
                        endcase
                    end
                end

                // Walk the table: first ready high-priority slot, else the
                // first ready normal one.
                S_SCAN: begin
                    if (r_idx != '0 && scan_ready
                        && (!r_best_found || (info_rdata.hi && !r_best_hi))) begin
                        r_best_found <= 1'b1;
                        r_best_hi    <= info_rdata.hi;
                        r_best_idx   <= scan_slot;
                        r_best_cat   <= info_rdata.cat;
                    end
                    if (r_idx == COUNT_W'(SLOT_COUNT)) begin
                        r_fsm <= S_DECIDE;
                    end
                    r_idx <= r_idx + 1'b1;
                end

                S_DECIDE: begin
                    if (!r_best_found) begin
                        r_eng <= ENG_RETRY;
                    end else if (!r_cloud) begin
                        r_last <= RC_NOCLOUD;
                    end else begin
                        r_eng          <= ENG_PROC;
                        r_pending      <= 1'b1;
                        r_attempt_slot <= r_best_idx;
                        r_gv           <= 1'b1;
                        r_gcat         <= r_best_cat;
                    end
                    r_fsm <= S_RESULT;
                end

                S_OUT_READ: begin
                    r_fsm <= S_OUT_UPD;
                end

                // Apply the outcome of the outstanding attempt.
                S_OUT_UPD: begin
                    r_pending <= 1'b0;
                    r_fsm     <= S_RESULT;
                    if (slot_hit) begin
                        if (r_ok) begin
                            r_clr                        <= out_cat_bit;
                            r_slot_valid[r_attempt_slot] <= 1'b0;
                            r_cat_present                <= r_cat_present & ~out_cat_bit;
                            r_used                       <= r_used - 1'b1;
                            r_success_total              <= r_success_total + 1'b1;
                            r_last                       <= RC_OK;
                            r_last_success               <= r_now;
                            r_eng <= (r_used > COUNT_W'(1)) ? ENG_RETRY : ENG_IDLE;
                        end else begin
                            r_retry_total <= r_retry_total + 1'b1;
                            r_last        <= RC_FAIL;
                            if (att_next >= r_max_att) begin
                                r_slot_valid[r_attempt_slot] <= 1'b0;
                                r_cat_present <= r_cat_present & ~out_cat_bit;
                                r_used        <= r_used - 1'b1;
                                r_drop_total  <= r_drop_total + 1'b1;
                                r_drop        <= 1'b1;
                                r_eng <= (r_used > COUNT_W'(1)) ? ENG_RETRY : ENG_IDLE;
                            end else begin
                                r_eng    <= ENG_RETRY;
                                r_delay  <= DELAY_W'(r_base);
                                r_bo_cnt <= att_next;
                                r_fsm    <= S_BACKOFF;
                            end
                        end
                    end
                end

                // Double the delay once a cycle up to the cap; the new ready
                // time is written when the count runs out.
                S_BACKOFF: begin
                    if (r_bo_cnt == '0) begin
                        r_fsm <= S_RESULT;
                    end else if (delay_dbl >= cap_ext) begin
                        r_delay  <= cap_ext;
                        r_bo_cnt <= '0;
                    end else begin
                        r_delay  <= delay_dbl;
                        r_bo_cnt <= r_bo_cnt - 1'b1;
                    end
                end

                // Load the result register once it is free.
                S_RESULT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_gv      <= r_gv;
                        r_o_gcat    <= r_gcat;
                        r_o_clr     <= r_clr;
                        r_o_rc      <= rc_now;
                        r_o_eng     <= r_eng;
                        r_o_pend    <= PEND_W'(r_used);
                        r_o_drop    <= r_drop;
                        r_o_succ    <= r_success_total;
                        r_o_dropc   <= r_drop_total;
                        r_o_retry   <= r_retry_total;
                        r_o_last    <= r_last_success;
                        r_fsm       <= S_IDLE;
                    end
                end

                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_grant_valid       = r_o_gv;
    assign o_grant_category    = r_o_gcat;
    assign o_clear_dirty_mask  = r_o_clr;
    assign o_result_code       = r_o_rc;
    assign o_engine_state      = r_o_eng;
    assign o_pending_count     = r_o_pend;
    assign o_item_dropped      = r_o_drop;
    assign o_success_count     = r_o_succ;
    assign o_drop_count        = r_o_dropc;
    assign o_retry_count_total = r_o_retry;
    assign o_last_success_ms   = r_o_last;

    // The fill count always matches the number of valid slots.
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_used))
        else $error("fill count differs from number of valid slots");

    // Each queued slot holds a distinct category.
    a_present_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_cat_present) == 32'(r_used))
        else $error("category presence differs from fill count");

    // An outstanding attempt always refers to a slot still in use.
    a_attempt_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_slot_valid[r_attempt_slot])
        else $error("outstanding attempt refers to a free slot");

    // A granted item always reports the processing state.
    a_grant_processing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_gv) |-> (r_o_eng == ENG_PROC))
        else $error("grant reported outside the processing state");

    // At most one dirty flag is released per item.
    a_clear_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_o_clr))
        else $error("more than one dirty flag released");

endmodule

// File: tb/retry_queue_backoff_scheduler_tb.sv
// ----------------------------------------------------------------------------
// retry_queue_backoff_scheduler_tb
// Self-checking bench for the retry queue scheduler. Each accepted item is run
// through a behavioural copy of the slot table, the backoff rule and the
// counters, and the predicted result is queued. Every result item leaving the
// block is compared field by field with the oldest prediction. Directed items
// walk each mode and corner; random traffic then runs under several register
// settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module retry_queue_backoff_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqbs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 235;

    // Mode codes that the block does not define.
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]    mode;
        logic [CAT_COUNT-1:0] dirty;
        logic [TIME_W-1:0]    now;
        logic                 cloud;
        logic                 ok;
    } sched_item_t;

    typedef struct {
        logic                 grant;
        logic [CAT_W-1:0]     gcat;
        logic [CAT_COUNT-1:0] clr;
        t_result              rc;
        t_eng                 eng;
        logic [PEND_W-1:0]    pend;
        logic                 dropped;
        logic [CNT_W-1:0]     succ;
        logic [CNT_W-1:0]     drops;
        logic [CNT_W-1:0]     retries;
        logic [TIME_W-1:0]    last_ok;
    } sched_result_t;

    // Block ports.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [MODE_W-1:0]     i_mode;
    logic [CAT_COUNT-1:0]  i_dirty_flags;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  i_cloud_ready;
    logic                  i_attempt_ok;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_grant_valid;
    logic [CAT_W-1:0]      o_grant_category;
    logic [CAT_COUNT-1:0]  o_clear_dirty_mask;
    logic [RC_W-1:0]       o_result_code;
    logic [ENG_W-1:0]      o_engine_state;
    logic [PEND_W-1:0]     o_pending_count;
    logic                  o_item_dropped;
    logic [CNT_W-1:0]      o_success_count;
    logic [CNT_W-1:0]      o_drop_count;
    logic [CNT_W-1:0]      o_retry_count_total;
    logic [TIME_W-1:0]     o_last_success_ms;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    retry_queue_backoff_scheduler u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_dirty_flags       (i_dirty_flags),
        .i_now_ms            (i_now_ms),
        .i_cloud_ready       (i_cloud_ready),
        .i_attempt_ok        (i_attempt_ok),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_grant_valid       (o_grant_valid),
        .o_grant_category    (o_grant_category),
        .o_clear_dirty_mask  (o_clear_dirty_mask),
        .o_result_code       (o_result_code),
        .o_engine_state      (o_engine_state),
        .o_pending_count     (o_pending_count),
        .o_item_dropped      (o_item_dropped),
        .o_success_count     (o_success_count),
        .o_drop_count        (o_drop_count),
        .o_retry_count_total (o_retry_count_total),
        .o_last_success_ms   (o_last_success_ms),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Predictor state: registers, slot table, attempt tracking and counters.
    logic                 cfg_enabled;
    logic [ATT_W-1:0]     cfg_max_att;
    logic [BASE_W-1:0]    cfg_base;
    logic [CAP_W-1:0]     cfg_cap;
    logic [CAT_COUNT-1:0] cfg_hp_mask;

    logic                 sl_valid [SLOT_COUNT];
    logic [CAT_W-1:0]     sl_cat   [SLOT_COUNT];
    logic                 sl_hi    [SLOT_COUNT];
    logic [ATT_W-1:0]     sl_att   [SLOT_COUNT];
    logic [TIME_W-1:0]    sl_ready [SLOT_COUNT];
    int                   used;
    logic                 attempt_busy;
    logic [SLOT_W-1:0]    attempt_idx;
    t_eng                 eng_state;
    t_result              last_rc;
    logic [CNT_W-1:0]     n_success;
    logic [CNT_W-1:0]     n_drop;
    logic [CNT_W-1:0]     n_retry;
    logic [TIME_W-1:0]    last_ok_time;

    sched_result_t        expected_q [$];

    // Bench bookkeeping.
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    logic [TIME_W-1:0]    clock_ms;
    int                   cycle_count = 0;
    int                   mismatches = 0;
    int                   n_items_sent = 0;
    int                   n_results = 0;
    int                   n_grants = 0;
    int                   n_cfg_writes = 0;

    // Clock and cycle count.
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Predictor reset to the block's reset state.
    task automatic reset_model();
        cfg_enabled  = RST_ENABLED;
        cfg_max_att  = RST_MAX_ATT;
        cfg_base     = RST_BASE;
        cfg_cap      = RST_CAP;
        cfg_hp_mask  = RST_HP_MASK;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            sl_valid[i] = 1'b0;
            sl_cat[i]   = '0;
            sl_hi[i]    = 1'b0;
            sl_att[i]   = '0;
            sl_ready[i] = '0;
        end
        used         = 0;
        attempt_busy = 1'b0;
        attempt_idx  = '0;
        eng_state    = ENG_IDLE;
        last_rc      = RC_NOCHG;
        n_success    = '0;
        n_drop       = '0;
        n_retry      = '0;
        last_ok_time = '0;
    endtask

    function automatic t_eng occupied_state();
        return (used > 0) ? ENG_RETRY : ENG_IDLE;
    endfunction

    // Inserts a category unless already queued; returns 1 when the table is full.
    function automatic logic place_category(logic [CAT_W-1:0] cat);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sl_valid[i] && sl_cat[i] == cat) return 1'b0;
        end
        if (used >= SLOT_COUNT) return 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!sl_valid[i]) begin
                sl_valid[i] = 1'b1;
                sl_cat[i]   = cat;
                sl_hi[i]    = cfg_hp_mask[cat];
                sl_att[i]   = '0;
                sl_ready[i] = '0;
                used++;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void enqueue_dirty(logic [CAT_COUNT-1:0] dirty);
        for (int c = 0; c < CAT_COUNT; c++) begin
            if (dirty[c]) void'(place_category(CAT_W'(c)));
        end
        if (eng_state == ENG_IDLE && used > 0) eng_state = ENG_RETRY;
    endfunction

    // Works out the result of one accepted item and advances the predictor.
    function automatic sched_result_t predict_item(sched_item_t it);
        sched_result_t r;
        int            best;
        int            best_pri;
        int            pri;
        int            s;
        logic [63:0]   delay;
        r.grant   = 1'b0;
        r.gcat    = '0;
        r.clr     = '0;
        r.rc      = last_rc;
        r.dropped = 1'b0;
        if (!cfg_enabled) begin
            r.rc = RC_DIS;
        end else begin
            case (it.mode)
                MODE_TICK: begin
                    enqueue_dirty(it.dirty);
                    if (!attempt_busy) begin
                        if (used == 0) begin
                            eng_state = ENG_IDLE;
                        end else begin
                            // High priority first, lowest ready slot on ties.
                            best     = -1;
                            best_pri = 2;
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                pri = sl_hi[i] ? 0 : 1;
                                if (sl_valid[i] && sl_ready[i] <= it.now && pri < best_pri) begin
                                    best_pri = pri;
                                    best     = i;
                                end
                            end
                            if (best < 0) begin
                                eng_state = ENG_RETRY;
                            end else if (!it.cloud) begin
                                last_rc = RC_NOCLOUD;
                            end else begin
                                eng_state    = ENG_PROC;
                                attempt_busy = 1'b1;
                                attempt_idx  = SLOT_W'(best);
                                r.grant      = 1'b1;
                                r.gcat       = sl_cat[best];
                            end
                        end
                    end
                    r.rc = last_rc;
                end
                MODE_OUTCOME: begin
                    s = attempt_idx;
                    if (attempt_busy && sl_valid[s]) begin
                        attempt_busy = 1'b0;
                        if (it.ok) begin
                            r.clr        = CAT_COUNT'(32'd1 << sl_cat[s]);
                            sl_valid[s]  = 1'b0;
                            used--;
                            n_success++;
                            last_rc      = RC_OK;
                            last_ok_time = it.now;
                            eng_state    = occupied_state();
                        end else begin
                            sl_att[s] = sl_att[s] + 1'b1;
                            n_retry++;
                            last_rc   = RC_FAIL;
                            if (sl_att[s] >= cfg_max_att) begin
                                sl_valid[s] = 1'b0;
                                used--;
                                n_drop++;
                                r.dropped   = 1'b1;
                                eng_state   = occupied_state();
                            end else begin
                                // Doubling per failed attempt, held at the cap.
                                delay = 64'(cfg_base);
                                for (int k = 0; k < sl_att[s]; k++) begin
                                    delay = delay * 2;
                                    if (delay >= 64'(cfg_cap)) begin
                                        delay = 64'(cfg_cap);
                                        break;
                                    end
                                end
                                sl_ready[s] = it.now + delay[TIME_W-1:0];
                                eng_state   = ENG_RETRY;
                            end
                        end
                    end else begin
                        attempt_busy = 1'b0;
                    end
                    r.rc = last_rc;
                end
                MODE_CANCEL: begin
                    for (int i = 0; i < SLOT_COUNT; i++) sl_valid[i] = 1'b0;
                    used         = 0;
                    attempt_busy = 1'b0;
                    eng_state    = ENG_IDLE;
                    last_rc      = RC_CANCEL;
                    r.rc         = RC_CANCEL;
                end
                MODE_RETRY_NOW: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (sl_valid[i]) sl_ready[i] = '0;
                    end
                    enqueue_dirty(it.dirty);
                    if (used > 0) eng_state = ENG_RETRY;
                    r.rc = RC_OK;
                end
                MODE_FORCE: begin
                    r.rc = RC_OK;
                    for (int c = 0; c < CAT_COUNT; c++) begin
                        if (place_category(CAT_W'(c))) r.rc = RC_FULL;
                    end
                end
                default: begin
                    r.rc = last_rc;
                end
            endcase
        end
        r.eng     = eng_state;
        r.pend    = PEND_W'(used);
        r.succ    = n_success;
        r.drops   = n_drop;
        r.retries = n_retry;
        r.last_ok = last_ok_time;
        return r;
    endfunction

    function automatic sched_item_t make_item(logic [MODE_W-1:0] mode,
                                              logic [CAT_COUNT-1:0] dirty,
                                              logic [TIME_W-1:0] now,
                                              logic cloud, logic ok);
        sched_item_t it;
        it.mode  = mode;
        it.dirty = dirty;
        it.now   = now;
        it.cloud = cloud;
        it.ok    = ok;
        return it;
    endfunction

    // Sends one item after a random gap and records its prediction on acceptance.
    task automatic send_item(sched_item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_mode        <= it.mode;
        i_dirty_flags <= it.dirty;
        i_now_ms      <= it.now;
        i_cloud_ready <= it.cloud;
        i_attempt_ok  <= it.ok;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(predict_item(it));
        n_items_sent++;
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, issued only once the block has gone quiet.
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ENABLED: begin
                cfg_enabled = data[0];
                eng_state   = cfg_enabled ? occupied_state() : ENG_DIS;
            end
            CFG_MAX_ATT: cfg_max_att = data[ATT_W-1:0];
            CFG_BASE:    cfg_base    = data[BASE_W-1:0];
            CFG_CAP:     cfg_cap     = data[CAP_W-1:0];
            CFG_HP_MASK: cfg_hp_mask = data[CAT_COUNT-1:0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] max_att, logic [CFG_DATA_W-1:0] base,
                                  logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] mask);
        cfg_write(CFG_MAX_ATT, max_att);
        cfg_write(CFG_BASE, base);
        cfg_write(CFG_CAP, cap);
        cfg_write(CFG_HP_MASK, mask);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("Mismatch on result %0d, %s: expected %0h, actual %0h",
                         n_results, name, exp_v, act_v);
            end
        end
    endtask

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        sched_result_t exp_r;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && !i_stall) begin
            n_results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Result %0d arrived with no prediction waiting", n_results);
                end
            end else begin
                exp_r = expected_q.pop_front();
                check_field("grant_valid", 32'(exp_r.grant), 32'(o_grant_valid));
                check_field("grant_category", 32'(exp_r.gcat), 32'(o_grant_category));
                check_field("clear_dirty_mask", 32'(exp_r.clr), 32'(o_clear_dirty_mask));
                check_field("result_code", 32'(exp_r.rc), 32'(o_result_code));
                check_field("engine_state", 32'(exp_r.eng), 32'(o_engine_state));
                check_field("pending_count", 32'(exp_r.pend), 32'(o_pending_count));
                check_field("item_dropped", 32'(exp_r.dropped), 32'(o_item_dropped));
                check_field("success_count", exp_r.succ, o_success_count);
                check_field("drop_count", exp_r.drops, o_drop_count);
                check_field("retry_count_total", exp_r.retries, o_retry_count_total);
                check_field("last_success_ms", exp_r.last_ok, o_last_success_ms);
                if (exp_r.grant) n_grants++;
            end
        end
    end

    // Every mode and the named corner cases, under the reset settings.
    task automatic test_directed_modes();
        // Report with no attempt outstanding is ignored; empty tick stays idle.
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd0, 1'b1, 1'b1));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd0, 1'b1, 1'b0));
        // Cloud not ready: the category is queued but not granted.
        send_item(make_item(MODE_TICK, 5'b00010, 32'd10, 1'b0, 1'b0));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd20, 1'b1, 1'b0));
        // Tick while an attempt is outstanding still enqueues.
        send_item(make_item(MODE_TICK, 5'b11100, 32'd30, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd40, 1'b1, 1'b0));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd50, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd60, 1'b1, 1'b1));
        send_item(make_item(MODE_TICK, 5'b00001, 32'd70, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd80, 1'b1, 1'b0));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd90, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd91, 1'b1, 1'b0));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd92, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd93, 1'b1, 1'b0));
        // Every slot now in backoff: nothing ready.
        send_item(make_item(MODE_TICK, 5'b00000, 32'd100, 1'b1, 1'b0));
        // Retry-now clears the backoff, so the next tick grants at once.
        send_item(make_item(MODE_RETRY_NOW, 5'b00000, 32'd110, 1'b0, 1'b0));
        send_item(make_item(MODE_TICK, 5'b00000, 32'd120, 1'b1, 1'b0));
        // Cancel drops the outstanding attempt; the late report is ignored.
        send_item(make_item(MODE_CANCEL, 5'b11111, 32'd125, 1'b1, 1'b1));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'd130, 1'b1, 1'b1));
        send_item(make_item(MODE_FORCE, 5'b00000, 32'd140, 1'b0, 1'b0));
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
            send_item(make_item(MODE_W'(m), 5'b11111, 32'hFFFF_FFFF, 1'b1, 1'b1));
        end
        // Largest timestamp.
        send_item(make_item(MODE_TICK, 5'b11111, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, 32'hFFFF_FFFF, 1'b1, 1'b1));
        clock_ms = 32'd200;
    endtask

    // A zero attempt limit drops a slot on its first failure.
    task automatic test_zero_max_attempts();
        cfg_write(CFG_MAX_ATT, 20'hFFFF0);
        repeat (2) begin
            send_item(make_item(MODE_TICK, 5'b01000, clock_ms, 1'b1, 1'b0));
            send_item(make_item(MODE_OUTCOME, 5'b00000, clock_ms, 1'b1, 1'b0));
        end
        cfg_write(CFG_MAX_ATT, 20'd5);
    endtask

    // With the engine disabled every mode reports disabled and changes nothing.
    task automatic test_disable();
        cfg_write(CFG_ENABLED, 20'hFFFFE);
        send_item(make_item(MODE_TICK, 5'b11111, clock_ms, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, clock_ms, 1'b1, 1'b1));
        send_item(make_item(MODE_FORCE, 5'b00000, clock_ms, 1'b1, 1'b0));
        send_item(make_item(MODE_CANCEL, 5'b00000, clock_ms, 1'b1, 1'b0));
        cfg_write(CFG_ENABLED, 20'd1);
        send_item(make_item(MODE_TICK, 5'b00000, clock_ms, 1'b1, 1'b0));
        send_item(make_item(MODE_OUTCOME, 5'b00000, clock_ms, 1'b1, 1'b1));
    endtask

    // Random traffic: mostly grant and report pairs, with the other modes and
    // some malformed items mixed in. Ignored items are not counted.
    task automatic run_random_phase(int n_items, int tx_pct, int rx_pct);
        sched_item_t it;
        int          done;
        int          pick;
        int          step;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < n_items) begin
            // Time mostly creeps forward, sometimes jumps or lands anywhere.
            step = $urandom_range(99);
            if (step < 2)
                clock_ms = $urandom;
            else if (step < 3)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(70000);
            else if (step < 8)
                clock_ms += $urandom_range(200000);
            else
                clock_ms += $urandom_range(1500);
            it.now   = clock_ms;
            it.dirty = ($urandom_range(2) == 0) ? CAT_COUNT'($urandom) : '0;
            it.cloud = ($urandom_range(7) != 0);
            it.ok    = $urandom_range(1);
            pick     = $urandom_range(99);
            if (attempt_busy && pick < 80)
                it.mode = MODE_OUTCOME;
            else if (pick < 85)
                it.mode = attempt_busy ? MODE_TICK : ((pick < 80) ? MODE_TICK : MODE_OUTCOME);
            else begin
                case ($urandom_range(9))
                    0, 1, 2: it.mode = MODE_RETRY_NOW;
                    3, 4:    it.mode = MODE_FORCE;
                    5:       it.mode = MODE_CANCEL;
                    6:       it.mode = MODE_W'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
                    default: begin
                        it.mode  = MODE_W'($urandom);
                        it.dirty = CAT_COUNT'($urandom);
                        it.now   = $urandom;
                    end
                endcase
            end
            if (!(it.mode == MODE_OUTCOME && !attempt_busy) && it.mode <= MODE_FORCE) done++;
            send_item(it);
            if ($urandom_range(149) == 0) drain_results();
        end
    endtask

    // Random phases across register settings, extremes among them.
    task automatic test_random_traffic();
        run_random_phase(PHASE_ITEMS, 35, 55);
        apply_settings(20'd1, 20'd1, 20'hFFFFF, 20'd31);
        run_random_phase(PHASE_ITEMS, 35, 55);
        apply_settings(20'd15, 20'd65535, 20'd1, 20'd0);
        run_random_phase(PHASE_ITEMS, 55, 35);
        apply_settings(20'd15, 20'd65535, 20'hFFFFF, CFG_DATA_W'($urandom_range(31)));
        run_random_phase(PHASE_ITEMS, 55, 35);
        apply_settings(CFG_DATA_W'($urandom_range(15, 1)), CFG_DATA_W'($urandom_range(65535, 1)),
                       CFG_DATA_W'($urandom_range(20'hFFFFF, 1)),
                       CFG_DATA_W'($urandom_range(31)));
        run_random_phase(PHASE_ITEMS, 0, 0);
        apply_settings(20'd3, 20'd500, 20'd5000, CFG_DATA_W'($urandom_range(31)));
        run_random_phase(PHASE_ITEMS, 0, 0);
    endtask

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_mode        = MODE_TICK;
        i_dirty_flags = '0;
        i_now_ms      = '0;
        i_cloud_ready = 1'b0;
        i_attempt_ok  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_ENABLED;
        i_cfg_data    = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        clock_ms      = '0;
        reset_model();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_modes();
        test_zero_max_attempts();
        test_disable();
        test_random_traffic();
        drain_results();

        $display("Run summary: %0d items sent, %0d results checked, %0d register writes, %0d mismatches.",
                 n_items_sent, n_results, n_cfg_writes, mismatches);
        $display("Scheduler activity: %0d grants, %0d successes, %0d failed attempts, %0d drops.",
                 n_grants, n_success, n_retry, n_drop);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: retry_queue_backoff_scheduler.f
sv/rqbs_pkg.sv
sv/rqbs_ram.sv
sv/retry_queue_backoff_scheduler.sv
tb/retry_queue_backoff_scheduler_tb.sv
